// ===== rtl/cca_pkg.sv =====
// Package of the cluster cache aging LRU block: field widths, reset values and codes.
// Used by the interfaces, the cache cell and the top level; depends on nothing.
`default_nettype none

package cca_pkg;

  localparam int unsigned DEF_ENTRIES  = 16;
  localparam int unsigned DEF_TAG_BITS = 32;

  localparam int unsigned CLUSTER_W = 32;
  localparam int unsigned ENTRY_W   = 4;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned AGE_W     = 8;

  localparam logic [AGE_W-1:0] AGE_START_RST = 8'd128;
  localparam logic [AGE_W-1:0] AGE_LOWEST    = 8'd1;
  localparam logic [AGE_W-1:0] AGE_MAX       = 8'hFF;

  typedef enum logic [STATUS_W-1:0] {
    STS_HIT  = 2'd0,
    STS_MISS = 2'd1,
    STS_ERR  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_TOUCH,
    UPD_FILL,
    UPD_FILL_FAIL
  } upd_op_e;

endpackage

`default_nettype wire

// ===== rtl/cca_ifs.sv =====
// Channel interfaces of the cluster cache aging LRU block: request, response and configuration.
// Depends on cca_pkg for the field widths.
`default_nettype none

interface cca_req_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [cca_pkg::CLUSTER_W-1:0] cluster;
  logic                          writeback_fails;
  logic                          fill_fails;

  modport source (output valid, kind, cluster, writeback_fails, fill_fails, input ready);
  modport sink   (input valid, kind, cluster, writeback_fails, fill_fails, output ready);
endinterface

interface cca_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [cca_pkg::STATUS_W-1:0]  status;
  logic [cca_pkg::ENTRY_W-1:0]   entry;
  logic                          writeback_needed;
  logic [cca_pkg::CLUSTER_W-1:0] writeback_cluster;
  logic                          fill_needed;

  modport source (output valid, status, entry, writeback_needed, writeback_cluster,
                  fill_needed, input ready);
  modport sink   (input valid, status, entry, writeback_needed, writeback_cluster,
                  fill_needed, output ready);
endinterface

interface cca_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [cca_pkg::AGE_W-1:0] age_start;

  modport source (output valid, age_start, input ready);
  modport sink   (input valid, age_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/cca_cell.sv =====
// One cache entry of the chain: tag, age and dirty mark, the search stage that merges this
// entry into the passing search packet, and the local update. Depends on cca_pkg.
`default_nettype none

module cca_cell #(
  parameter int unsigned ENTRIES  = cca_pkg::DEF_ENTRIES,
  parameter int unsigned TAG_BITS = cca_pkg::DEF_TAG_BITS,
  parameter int unsigned INDEX    = 0,
  localparam int unsigned IDX_W   = $clog2(ENTRIES),
  localparam int unsigned AGE_W   = cca_pkg::AGE_W,
  localparam int unsigned SRCH_W  = 2 * IDX_W + 2 * AGE_W + 2 + TAG_BITS,
  localparam int unsigned UPD_W   = $bits(cca_pkg::upd_op_e) + IDX_W + 2 * AGE_W + 1 + TAG_BITS
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire [TAG_BITS-1:0]   key_i,
  input  wire [SRCH_W-1:0]     srch_i,
  output logic [SRCH_W-1:0]    srch_o,
  input  wire [UPD_W-1:0]      upd_i
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  typedef struct packed {
    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic [AGE_W-1:0]    hit_age;
    logic [AGE_W-1:0]    low_age;
    logic [IDX_W-1:0]    vic_idx;
    logic                vic_dirty;
    logic [TAG_BITS-1:0] vic_tag;
  } srch_t;

  typedef struct packed {
    cca_pkg::upd_op_e    op;
    logic [IDX_W-1:0]    idx;
    logic [AGE_W-1:0]    ref_age;
    logic [AGE_W-1:0]    start_age;
    logic                write;
    logic [TAG_BITS-1:0] tag;
  } upd_t;

  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic [AGE_W-1:0]    age_q, age_d;
  logic                dirty_q, dirty_d;
  srch_t               srch_q, srch_d;
  srch_t               srch_in;
  upd_t                upd_in;
  logic                valid;
  logic                mine;

  assign srch_in = srch_i;
  assign upd_in  = upd_i;
  assign valid   = (age_q != '0);
  assign mine    = (upd_in.idx == MY_IDX);

  always_comb begin
    srch_d = srch_in;
    if (!srch_in.hit && valid && (tag_q == key_i)) begin
      srch_d.hit     = 1'b1;
      srch_d.hit_idx = MY_IDX;
      srch_d.hit_age = age_q;
    end
    if ((age_q < srch_in.low_age) || (INDEX == 0)) begin
      srch_d.low_age   = age_q;
      srch_d.vic_idx   = MY_IDX;
      srch_d.vic_dirty = valid && dirty_q;
      srch_d.vic_tag   = tag_q;
    end
  end

  always_comb begin
    tag_d   = tag_q;
    age_d   = age_q;
    dirty_d = dirty_q;
    case (upd_in.op)
      cca_pkg::UPD_TOUCH: begin
        if (mine) begin
          age_d   = upd_in.start_age;
          dirty_d = dirty_q || upd_in.write;
        end else if (valid && (age_q > upd_in.ref_age)) begin
          age_d = age_q >> 1;
        end
      end
      cca_pkg::UPD_FILL: begin
        if (mine) begin
          tag_d   = upd_in.tag;
          age_d   = upd_in.start_age;
          dirty_d = upd_in.write;
        end else if (valid && (age_q > upd_in.ref_age)) begin
          age_d = age_q >> 1;
        end
      end
      cca_pkg::UPD_FILL_FAIL: begin
        if (mine) begin
          tag_d   = upd_in.tag;
          age_d   = '0;
          dirty_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q   <= '0;
      dirty_q <= 1'b0;
    end else begin
      age_q   <= age_d;
      dirty_q <= dirty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    srch_q <= srch_d;
  end

  assign srch_o = srch_q;

endmodule

`default_nettype wire

// ===== rtl/cluster_cache_aging_lru_top.sv =====
// Top level of the cluster cache aging LRU block: sequencer, configuration register and the
// chain of cca_cell entries. Depends on cca_pkg, cca_ifs.sv and cca_cell.
//
//   Channel  Direction  Payload
//   req      in         kind, cluster, writeback_fails, fill_fails
//   rsp      out        status, entry, writeback_needed, writeback_cluster, fill_needed
//   cfg      in         age_start (always ready)
//
// Each transaction walks the search packet through the chain one cell per cycle; then the
// decide step picks the entry, and the emit step updates the cells and fills the output register.
// Reset clears every age and dirty mark at once; tags are not reset.
// The response sits in an output register, so a new request is taken while it waits;
// a second result waits for that register to empty before the block is ready again.
`default_nettype none

module cluster_cache_aging_lru_top #(
  parameter int unsigned ENTRIES  = cca_pkg::DEF_ENTRIES,
  parameter int unsigned TAG_BITS = cca_pkg::DEF_TAG_BITS
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  cca_req_if.sink    req,
  cca_rsp_if.source  rsp,
  cca_cfg_if.sink    cfg
);

  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam int unsigned AGE_W     = cca_pkg::AGE_W;
  localparam int unsigned CLUSTER_W = cca_pkg::CLUSTER_W;
  localparam int unsigned ENTRY_W   = cca_pkg::ENTRY_W;

  typedef struct packed {
    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic [AGE_W-1:0]    hit_age;
    logic [AGE_W-1:0]    low_age;
    logic [IDX_W-1:0]    vic_idx;
    logic                vic_dirty;
    logic [TAG_BITS-1:0] vic_tag;
  } srch_t;

  typedef struct packed {
    cca_pkg::upd_op_e    op;
    logic [IDX_W-1:0]    idx;
    logic [AGE_W-1:0]    ref_age;
    logic [AGE_W-1:0]    start_age;
    logic                write;
    logic [TAG_BITS-1:0] tag;
  } upd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  localparam srch_t SRCH_START = '{
    hit:       1'b0,
    hit_idx:   '0,
    hit_age:   '0,
    low_age:   cca_pkg::AGE_MAX,
    vic_idx:   '0,
    vic_dirty: 1'b0,
    vic_tag:   '0
  };

  state_e                state_q;
  logic [IDX_W-1:0]      cnt_q;
  logic [AGE_W-1:0]      age_start_q;
  logic [AGE_W-1:0]      start_age;
  logic                  kind_q;
  logic [TAG_BITS-1:0]   key_q;
  logic                  wb_fail_q;
  logic                  fill_fail_q;
  upd_t                  upd_q;

  cca_pkg::status_e      res_status_q;
  logic [IDX_W-1:0]      res_idx_q;
  logic                  res_wb_q;
  logic [CLUSTER_W-1:0]  res_wbc_q;
  logic                  res_fill_q;

  logic                  out_valid_q;
  cca_pkg::status_e      out_status_q;
  logic [ENTRY_W-1:0]    out_entry_q;
  logic                  out_wb_q;
  logic [CLUSTER_W-1:0]  out_wbc_q;
  logic                  out_fill_q;

  srch_t                 chain [ENTRIES+1];
  srch_t                 last;

  cca_pkg::upd_op_e      dec_op;
  cca_pkg::status_e      dec_status;
  logic [IDX_W-1:0]      dec_idx;
  logic [AGE_W-1:0]      dec_ref;
  logic                  dec_wb;
  logic [CLUSTER_W-1:0]  dec_wbc;
  logic                  dec_fill;

  assign start_age = (age_start_q == '0) ? cca_pkg::AGE_LOWEST : age_start_q;

  assign chain[0] = SRCH_START;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    cca_cell #(
      .ENTRIES  (ENTRIES),
      .TAG_BITS (TAG_BITS),
      .INDEX    (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .key_i        (key_q),
      .srch_i       (chain[i]),
      .srch_o       (chain[i+1]),
      .upd_i        (upd_q)
    );
  end

  assign last = chain[ENTRIES];

  always_comb begin
    dec_op     = cca_pkg::UPD_NONE;
    dec_status = cca_pkg::STS_HIT;
    dec_idx    = last.hit_idx;
    dec_ref    = last.hit_age;
    dec_wb     = 1'b0;
    dec_wbc    = '0;
    dec_fill   = 1'b0;
    if (last.hit) begin
      dec_op = cca_pkg::UPD_TOUCH;
    end else begin
      dec_idx = last.vic_idx;
      dec_ref = '0;
      dec_wb  = last.vic_dirty;
      if (last.vic_dirty) begin
        dec_wbc = CLUSTER_W'(last.vic_tag);
      end
      if (last.vic_dirty && wb_fail_q) begin
        dec_status = cca_pkg::STS_ERR;
      end else begin
        dec_fill = 1'b1;
        if (fill_fail_q) begin
          dec_op     = cca_pkg::UPD_FILL_FAIL;
          dec_status = cca_pkg::STS_ERR;
        end else begin
          dec_op     = cca_pkg::UPD_FILL;
          dec_status = cca_pkg::STS_MISS;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      age_start_q  <= cca_pkg::AGE_START_RST;
      kind_q       <= 1'b0;
      key_q        <= '0;
      wb_fail_q    <= 1'b0;
      fill_fail_q  <= 1'b0;
      upd_q        <= '0;
      res_status_q <= cca_pkg::STS_HIT;
      res_idx_q    <= '0;
      res_wb_q     <= 1'b0;
      res_wbc_q    <= '0;
      res_fill_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= cca_pkg::STS_HIT;
      out_entry_q  <= '0;
      out_wb_q     <= 1'b0;
      out_wbc_q    <= '0;
      out_fill_q   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        age_start_q <= cfg.age_start;
      end
      if (out_valid_q && rsp.ready && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req.valid) begin
            kind_q      <= req.kind;
            key_q       <= TAG_BITS'(req.cluster);
            wb_fail_q   <= req.writeback_fails;
            fill_fail_q <= req.fill_fails;
            cnt_q       <= '0;
            state_q     <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (cnt_q == IDX_W'(ENTRIES - 1)) begin
            state_q <= ST_DECIDE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DECIDE: begin
          upd_q.op        <= dec_op;
          upd_q.idx       <= dec_idx;
          upd_q.ref_age   <= dec_ref;
          upd_q.start_age <= start_age;
          upd_q.write     <= kind_q;
          upd_q.tag       <= key_q;
          res_status_q    <= dec_status;
          res_idx_q       <= dec_idx;
          res_wb_q        <= dec_wb;
          res_wbc_q       <= dec_wbc;
          res_fill_q      <= dec_fill;
          state_q         <= ST_EMIT;
        end
        ST_EMIT: begin
          upd_q.op <= cca_pkg::UPD_NONE;
          if (!out_valid_q || rsp.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_entry_q  <= ENTRY_W'(res_idx_q);
            out_wb_q     <= res_wb_q;
            out_wbc_q    <= res_wbc_q;
            out_fill_q   <= res_fill_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          upd_q.op <= cca_pkg::UPD_NONE;
          state_q  <= ST_IDLE;
        end
      endcase
    end
  end

  assign req.ready             = (state_q == ST_IDLE);
  assign cfg.ready             = 1'b1;
  assign rsp.valid             = out_valid_q;
  assign rsp.status            = out_status_q;
  assign rsp.entry             = out_entry_q;
  assign rsp.writeback_needed  = out_wb_q;
  assign rsp.writeback_cluster = out_wbc_q;
  assign rsp.fill_needed       = out_fill_q;

  a_no_update_when_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> (upd_q.op == cca_pkg::UPD_NONE))
    else $error("Entry update pending while a new request can be taken.");

  a_result_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("Response became valid outside the emit step.");

  a_hit_needs_nothing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && (rsp.status == cca_pkg::STS_HIT)) |->
      (!rsp.fill_needed && !rsp.writeback_needed))
    else $error("A hit asked for a fill or a write-back.");

endmodule

`default_nettype wire
